FILE: rtl/core/etts_pkg.sv
package etts_pkg;

	// Default widths of the position counters and the signed depth counter
	localparam int unsigned POSITION_BITS_DEF = 16;
	localparam int unsigned DEPTH_BITS_DEF    = 16;

	// Fixed widths of the reported fields
	localparam int unsigned OUT_BITS    = 16;
	localparam int unsigned CH_BITS     = 8;
	localparam int unsigned M_DATA_BITS = 56;

	// Input command codes
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Character codes
	localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_BITS-1:0] CH_E_LO  = 8'h65;
	localparam logic [CH_BITS-1:0] CH_E_UP  = 8'h45;
	localparam logic [CH_BITS-1:0] CH_OPEN  = 8'h28;
	localparam logic [CH_BITS-1:0] CH_CLOSE = 8'h29;
	localparam logic [CH_BITS-1:0] CH_STAR  = 8'h2A;
	localparam logic [CH_BITS-1:0] CH_SLASH = 8'h2F;
	localparam logic [CH_BITS-1:0] CH_CARET = 8'h5E;
	localparam logic [CH_BITS-1:0] CH_DOT   = 8'h2E;
	localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;

	// Operator that joins a term to the next one
	typedef enum logic [1:0] {
		JOIN_PLUS  = 2'd0,
		JOIN_MINUS = 2'd1,
		JOIN_NONE  = 2'd2
	} join_op_t;

	// One reported term
	typedef struct packed {
		logic [OUT_BITS-1:0] term_start;
		logic [OUT_BITS-1:0] term_len;
		join_op_t            join_op;
		logic [OUT_BITS-1:0] term_index;
		logic                final_term;
		logic                overflow;
	} result_t;

endpackage

FILE: rtl/core/etts_scan.sv
module etts_scan #(
	parameter int unsigned POSITION_BITS = etts_pkg::POSITION_BITS_DEF,
	parameter int unsigned DEPTH_BITS    = etts_pkg::DEPTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           command,
	input  logic [etts_pkg::CH_BITS-1:0]   ch,
	output logic                           emit,
	output etts_pkg::result_t              result
);
	import etts_pkg::*;

	typedef enum logic [2:0] {
		PH_OUT,
		PH_INT,
		PH_EXP_MARK,
		PH_EXP_SIGN,
		PH_EXP_DIG
	} phase_t;

	localparam logic [POSITION_BITS-1:0]    POS_MAX    = '1;
	localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
	localparam logic [OUT_BITS-1:0]         TERMS_MAX  = '1;

	// Scanner state
	logic signed [DEPTH_BITS-1:0] depth_q, depth_n;
	logic                         expect_q, expect_n;
	phase_t                       phase_q, phase_n;
	logic [POSITION_BITS-1:0]     pos_q, pos_n;
	logic [POSITION_BITS-1:0]     start_q, start_n;
	logic [OUT_BITS-1:0]          terms_q, terms_n;
	logic                         sat_q, sat_n;

	// Report a position-wide value on a 16-bit field, saturating
	function automatic logic [OUT_BITS-1:0] clamp_out(input logic [POSITION_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (|w[31:OUT_BITS]) ? '1 : w[OUT_BITS-1:0];
	endfunction

	// Classify the character, advance the number phase, find split points
	always_comb begin
		logic is_dig;
		logic is_dot;
		logic is_exp;
		logic is_sign;
		logic used;
		logic split;
		logic pos_sat;
		is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_dot  = (ch == CH_DOT);
		is_exp  = (ch == CH_E_LO) || (ch == CH_E_UP);
		is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
		pos_sat = (pos_q == POS_MAX);

		depth_n  = depth_q;
		expect_n = expect_q;
		phase_n  = phase_q;
		pos_n    = pos_q;
		start_n  = start_q;
		terms_n  = terms_q;
		sat_n    = sat_q;
		used     = 1'b0;
		split    = 1'b0;

		// Continue the current number literal if the character fits
		unique case (phase_q)
			PH_INT: begin
				if (is_dig || is_dot) begin
					used = 1'b1;
				end else if (is_exp) begin
					phase_n = PH_EXP_MARK;
					used    = 1'b1;
				end
			end
			PH_EXP_MARK: begin
				if (is_sign) begin
					phase_n = PH_EXP_SIGN;
					used    = 1'b1;
				end else if (is_dig) begin
					phase_n = PH_EXP_DIG;
					used    = 1'b1;
				end
			end
			PH_EXP_SIGN, PH_EXP_DIG: begin
				if (is_dig) begin
					phase_n = PH_EXP_DIG;
					used    = 1'b1;
				end
			end
			default: ;
		endcase

		// Handle as an ordinary character
		if (!used) begin
			phase_n = PH_OUT;
			if (is_dig || is_dot) begin
				phase_n  = PH_INT;
				expect_n = 1'b0;
			end else if (ch == CH_OPEN) begin
				if (depth_q == DEPTH_MAX) sat_n = 1'b1;
				else depth_n = depth_q + DEPTH_BITS'(1);
				expect_n = 1'b1;
			end else if (ch == CH_CLOSE) begin
				if (depth_q == DEPTH_MIN) sat_n = 1'b1;
				else depth_n = depth_q - DEPTH_BITS'(1);
				expect_n = 1'b0;
			end else if ((ch == CH_STAR) || (ch == CH_SLASH) || (ch == CH_CARET)) begin
				expect_n = 1'b1;
			end else if (is_sign) begin
				split = (depth_q == '0) && !expect_q;
				if (split) begin
					if (terms_q == TERMS_MAX) sat_n = 1'b1;
					else terms_n = terms_q + OUT_BITS'(1);
					if (pos_sat) begin
						start_n = POS_MAX;
						sat_n   = 1'b1;
					end else begin
						start_n = pos_q + POSITION_BITS'(1);
					end
				end
				expect_n = 1'b1;
			end
		end

		// Count the position
		if (pos_sat) sat_n = 1'b1;
		else pos_n = pos_q + POSITION_BITS'(1);

		// Build the report from the state before this character; a split's overflow flag includes it
		result.term_start = clamp_out(start_q);
		result.term_len   = clamp_out(pos_q - start_q);
		result.term_index = terms_q;
		if (command == CMD_END) begin
			emit              = 1'b1;
			result.join_op    = JOIN_NONE;
			result.final_term = 1'b1;
			result.overflow   = sat_q;
		end else begin
			emit              = split;
			result.join_op    = (ch == CH_PLUS) ? JOIN_PLUS : JOIN_MINUS;
			result.final_term = 1'b0;
			result.overflow   = sat_n;
		end
	end

	// Hold state; clear it on reset and on the end command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			expect_q <= 1'b1;
			phase_q  <= PH_OUT;
			pos_q    <= '0;
			start_q  <= '0;
			terms_q  <= '0;
			sat_q    <= 1'b0;
		end else if (step) begin
			if (command == CMD_END) begin
				depth_q  <= '0;
				expect_q <= 1'b1;
				phase_q  <= PH_OUT;
				pos_q    <= '0;
				start_q  <= '0;
				terms_q  <= '0;
				sat_q    <= 1'b0;
			end else begin
				depth_q  <= depth_n;
				expect_q <= expect_n;
				phase_q  <= phase_n;
				pos_q    <= pos_n;
				start_q  <= start_n;
				terms_q  <= terms_n;
				sat_q    <= sat_n;
			end
		end
	end

endmodule

FILE: rtl/core/etts_out_reg.sv
module etts_out_reg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  etts_pkg::result_t                  result,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [etts_pkg::M_DATA_BITS-1:0]   m_tdata,
	output logic                               m_tlast
);
	import etts_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Hold the result until the downstream side takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	// Pack the fields, lowest first
	assign m_tvalid = valid_q;
	assign m_tlast  = data_q.final_term;
	assign m_tdata  = {5'b0, data_q.overflow, data_q.term_index, data_q.join_op,
		data_q.term_len, data_q.term_start};

endmodule

FILE: rtl/core/expression_top_level_term_splitter.sv
// Splits an arithmetic expression into its top-level additive terms. Feed one character per
// transfer with tuser low, and a transfer with tuser high to end the expression. A plus or
// minus at parenthesis depth zero that follows an operand closes a term and produces one
// output transfer carrying the term's start, length, joining operator and ordinal; signs
// inside number literals such as 2e+5 do not split. The end command always produces the
// final term (tlast high) and clears the scanner. The block takes one character per cycle
// unless the input stalls: the scanner state updates for each character, an input register
// and an output register bound the path, and the character that causes a result passes
// the input register before the result is loaded into the output register. Input stalls only
// while a result waits in the output register and the next character also produces a result.
module expression_top_level_term_splitter #(
	parameter int unsigned POSITION_BITS = etts_pkg::POSITION_BITS_DEF,
	parameter int unsigned DEPTH_BITS    = etts_pkg::DEPTH_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [etts_pkg::CH_BITS-1:0]       s_tdata,  // [7:0] ch
	input  logic                               s_tuser,  // [0] command
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] term_start, [31:16] term_len, [33:32] join_op, [49:34] term_index,
	// [50] overflow, [55:51] zero
	output logic [etts_pkg::M_DATA_BITS-1:0]   m_tdata,
	output logic                               m_tlast   // final_term
);
	import etts_pkg::*;

	logic               valid_s1;
	logic               command_s1;
	logic [CH_BITS-1:0] ch_s1;
	logic               emit;
	logic               advance;
	logic               out_free;
	result_t            result;

	// Move the registered character on unless its result is blocked
	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			command_s1 <= s_tuser;
			ch_s1      <= s_tdata;
		end
	end

	etts_scan #(
		.POSITION_BITS (POSITION_BITS),
		.DEPTH_BITS    (DEPTH_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.command (command_s1),
		.ch      (ch_s1),
		.emit    (emit),
		.result  (result)
	);

	etts_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.result   (result),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import etts_pkg::*;

	// Whitespace bytes; the scanner counts their positions and they end a number literal
	localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_BITS-1:0] CH_LF    = 8'h0A;
	localparam logic [CH_BITS-1:0] CH_CR    = 8'h0D;

	localparam int unsigned POS_W = POSITION_BITS_DEF;
	localparam int unsigned DEP_W = DEPTH_BITS_DEF;
	localparam logic signed [DEP_W-1:0] DEPTH_HI = {1'b0, {(DEP_W-1){1'b1}}};
	localparam logic signed [DEP_W-1:0] DEPTH_LO = {1'b1, {(DEP_W-1){1'b0}}};

	typedef enum logic [2:0] {
		NUM_OUT,
		NUM_INT,
		NUM_EXP_MARK,
		NUM_EXP_SIGN,
		NUM_EXP_DIG
	} num_phase_t;

	typedef struct {
		logic              cmd;
		logic [CH_BITS-1:0] ch;
		bit                typed;
		result_t           want;
	} dir_row_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [CH_BITS-1:0]     s_tdata  = '0;  // [7:0] ch
	logic                   s_tuser  = CMD_CHAR;  // [0] command
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_DATA_BITS-1:0] m_tdata;  // term_start, term_len, join_op, term_index, overflow
	logic                   m_tlast;  // final_term

	// Typed expectation that travels with the current input transfer
	logic    drv_typed = 1'b0;
	result_t drv_want  = '0;

	// Scanner copy
	logic signed [DEP_W-1:0] depth;
	bit                      want_operand;
	num_phase_t              phase;
	logic [POS_W-1:0]        pos;
	logic [POS_W-1:0]        term_start_pos;
	logic [OUT_BITS-1:0]     term_count;
	bit                      sat;

	result_t          pending_terms[$];
	int               mismatches = 0;
	bit               idle_on    = 1'b0;
	int               rx_hold    = 0;
	logic [CH_BITS-1:0] expr_buf[$];
	dir_row_t         dir_rows[27];

	expression_top_level_term_splitter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_digit(logic [CH_BITS-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [OUT_BITS-1:0] clamp_out(longint unsigned v);
		return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic void clear_scanner();
		depth          = '0;
		want_operand   = 1'b1;
		phase          = NUM_OUT;
		pos            = '0;
		term_start_pos = '0;
		term_count     = '0;
		sat            = 1'b0;
	endfunction

	function automatic result_t make_term(join_op_t op, logic fin);
		result_t t;
		t.term_start = clamp_out(64'(term_start_pos));
		t.term_len   = clamp_out(64'(pos - term_start_pos));
		t.join_op    = op;
		t.term_index = term_count;
		t.final_term = fin;
		t.overflow   = sat;
		return t;
	endfunction

	// Hand-typed term for the directed table; overflow is clear there
	function automatic result_t term(int start, int len, join_op_t op, int idx, logic fin);
		result_t t;
		t.term_start = OUT_BITS'(start);
		t.term_len   = OUT_BITS'(len);
		t.join_op    = op;
		t.term_index = OUT_BITS'(idx);
		t.final_term = fin;
		t.overflow   = 1'b0;
		return t;
	endfunction

	// Advance the scanner copy by one transfer; return 1 when a term is reported
	function automatic bit scan_step(input logic cmd, input logic [CH_BITS-1:0] c,
			output result_t r);
		bit taken;
		bit hit;
		taken = 1'b0;
		hit   = 1'b0;
		r     = '0;
		if (cmd == CMD_END) begin
			r = make_term(JOIN_NONE, 1'b1);
			clear_scanner();
			return 1'b1;
		end
		// continue a number literal where the character fits
		case (phase)
			NUM_INT: begin
				if (is_digit(c) || c == CH_DOT) taken = 1'b1;
				else if (c == CH_E_LO || c == CH_E_UP) begin
					phase = NUM_EXP_MARK;
					taken = 1'b1;
				end
			end
			NUM_EXP_MARK: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					phase = NUM_EXP_SIGN;
					taken = 1'b1;
				end else if (is_digit(c)) begin
					phase = NUM_EXP_DIG;
					taken = 1'b1;
				end
			end
			NUM_EXP_SIGN, NUM_EXP_DIG: begin
				if (is_digit(c)) begin
					phase = NUM_EXP_DIG;
					taken = 1'b1;
				end
			end
			default: ;
		endcase
		// otherwise end the number and treat the character on its own
		if (!taken) begin
			phase = NUM_OUT;
			if (is_digit(c) || c == CH_DOT) begin
				phase        = NUM_INT;
				want_operand = 1'b0;
			end else if (c == CH_OPEN) begin
				if (depth == DEPTH_HI) sat = 1'b1;
				else depth = depth + DEP_W'(1);
				want_operand = 1'b1;
			end else if (c == CH_CLOSE) begin
				if (depth == DEPTH_LO) sat = 1'b1;
				else depth = depth - DEP_W'(1);
				want_operand = 1'b0;
			end else if (c == CH_STAR || c == CH_SLASH || c == CH_CARET) begin
				want_operand = 1'b1;
			end else if (c == CH_PLUS || c == CH_MINUS) begin
				if (depth == 0 && !want_operand) begin
					r   = make_term((c == CH_PLUS) ? JOIN_PLUS : JOIN_MINUS, 1'b0);
					hit = 1'b1;
					if (term_count == '1) sat = 1'b1;
					else term_count = term_count + OUT_BITS'(1);
					if (pos == '1) begin
						term_start_pos = '1;
						sat            = 1'b1;
					end else begin
						term_start_pos = pos + POS_W'(1);
					end
				end
				want_operand = 1'b1;
			end
		end
		if (pos == '1) sat = 1'b1;
		else pos = pos + POS_W'(1);
		if (hit) r.overflow = sat;
		return hit;
	endfunction

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	// Append one byte to the expression being built
	function automatic void put_byte(logic [CH_BITS-1:0] b);
		expr_buf.insert(expr_buf.size(), b);
	endfunction

	// Random expression pieces
	function automatic void put_digits(int n);
		logic [CH_BITS-1:0] d;
		repeat (n) begin
			d = CH_BITS'($urandom_range(0, 9));
			put_byte(CH_ZERO + d);
		end
	endfunction

	function automatic void put_space();
		case ($urandom_range(0, 3))
			0: put_byte(CH_SPACE);
			1: put_byte(CH_TAB);
			2: put_byte(CH_LF);
			default: put_byte(CH_CR);
		endcase
	endfunction

	function automatic void put_number();
		put_digits($urandom_range(1, 3));
		if ($urandom_range(0, 3) == 0) begin
			put_byte(CH_DOT);
			put_digits($urandom_range(0, 2));
		end
		if ($urandom_range(0, 2) == 0) begin
			put_byte($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
			case ($urandom_range(0, 2))
				0: put_byte(CH_PLUS);
				1: put_byte(CH_MINUS);
				default: ;
			endcase
			// an exponent without digits is a broken literal
			put_digits($urandom_range(0, 2));
		end
	endfunction

	function automatic void put_expr(int lvl);
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			put_operand(lvl);
			if ($urandom_range(0, 4) == 0) put_space();
			if (i < n - 1) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: put_byte(CH_PLUS);
					4, 5, 6:    put_byte(CH_MINUS);
					7:          put_byte(CH_STAR);
					8:          put_byte(CH_SLASH);
					default:    put_byte(CH_CARET);
				endcase
				if ($urandom_range(0, 4) == 0) put_space();
			end
		end
	endfunction

	function automatic void put_operand(int lvl);
		logic [CH_BITS-1:0] b;
		case ($urandom_range(0, 9))
			5: begin
				repeat ($urandom_range(1, 3)) begin
					b = CH_BITS'($urandom_range(0, 25));
					put_byte(($urandom_range(0, 1) ? 8'h61 : 8'h41) + b);
				end
			end
			6, 7: begin
				if (lvl < 3) begin
					put_byte(CH_OPEN);
					put_expr(lvl + 1);
					// sometimes leave the group open
					if ($urandom_range(0, 15) != 0) put_byte(CH_CLOSE);
				end else begin
					put_number();
				end
			end
			8: begin
				put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
				put_operand(lvl);
			end
			9: begin
				b = CH_BITS'($urandom_range(0, 255));
				put_byte(b);
			end
			default: put_number();
		endcase
	endfunction

	task automatic send_item(input logic cmd, input logic [CH_BITS-1:0] c, input bit typed,
			input result_t want);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = int'($urandom_range(1, 17));
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tuser   <= cmd;
		s_tdata   <= c;
		drv_typed <= typed;
		drv_want  <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_terms.size() != 0) @(posedge clk);
	endtask

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold  <= 0;
		end else if (rx_hold > 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= (rx_hold == 1);
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_hold  <= int'($urandom_range(1, 17));
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Check result transfers and predict from input transfers
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		result_t pred;
		if (!arst_n) begin
			clear_scanner();
		end else begin
			if (m_tvalid && m_tready) begin
				seen.term_start = m_tdata[15:0];
				seen.term_len   = m_tdata[31:16];
				seen.join_op    = join_op_t'(m_tdata[33:32]);
				seen.term_index = m_tdata[49:34];
				seen.overflow   = m_tdata[50];
				seen.final_term = m_tlast;
				if (pending_terms.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected term, expected none actual start %0d len %0d",
						$time, seen.term_start, seen.term_len);
				end else begin
					want = pending_terms.pop_front();
					check_field("term_start", 64'(want.term_start), 64'(seen.term_start));
					check_field("term_len", 64'(want.term_len), 64'(seen.term_len));
					check_field("join_op", 64'(want.join_op), 64'(seen.join_op));
					check_field("term_index", 64'(want.term_index), 64'(seen.term_index));
					check_field("final_term", 64'(want.final_term), 64'(seen.final_term));
					check_field("overflow", 64'(want.overflow), 64'(seen.overflow));
				end
			end
			if (s_tvalid && s_tready) begin
				if (scan_step(s_tuser, s_tdata, pred))
					pending_terms.insert(pending_terms.size(), drv_typed ? drv_want : pred);
			end
		end
	end

	initial begin
		int               rand_items;
		bit               paused;
		logic [CH_BITS-1:0] junk;

		rand_items = 0;
		paused     = 1'b0;

		// Directed expression: exponent sign, groups, unbalanced close, odd bytes
		dir_rows = '{
			'{CMD_END,  8'h00,    1'b1, term(0, 0, JOIN_NONE, 0, 1'b1)},
			'{CMD_CHAR, "1",      1'b0, '0},
			'{CMD_CHAR, CH_E_LO,  1'b0, '0},
			'{CMD_CHAR, CH_PLUS,  1'b0, '0},
			'{CMD_CHAR, CH_MINUS, 1'b0, '0},
			'{CMD_CHAR, CH_OPEN,  1'b0, '0},
			'{CMD_CHAR, "2",      1'b0, '0},
			'{CMD_CHAR, CH_PLUS,  1'b0, '0},
			'{CMD_CHAR, "3",      1'b0, '0},
			'{CMD_CHAR, CH_CLOSE, 1'b0, '0},
			'{CMD_CHAR, CH_STAR,  1'b0, '0},
			'{CMD_CHAR, CH_DOT,   1'b0, '0},
			'{CMD_CHAR, CH_E_UP,  1'b0, '0},
			'{CMD_CHAR, "7",      1'b0, '0},
			'{CMD_CHAR, CH_TAB,   1'b0, '0},
			'{CMD_CHAR, CH_PLUS,  1'b0, '0},
			'{CMD_CHAR, CH_CLOSE, 1'b0, '0},
			'{CMD_CHAR, CH_MINUS, 1'b0, '0},
			'{CMD_CHAR, CH_OPEN,  1'b0, '0},
			'{CMD_CHAR, 8'hFF,    1'b0, '0},
			'{CMD_CHAR, "8",      1'b0, '0},
			'{CMD_CHAR, CH_CARET, 1'b0, '0},
			'{CMD_CHAR, CH_SLASH, 1'b0, '0},
			'{CMD_CHAR, 8'h00,    1'b0, '0},
			'{CMD_CHAR, "9",      1'b0, '0},
			'{CMD_CHAR, CH_PLUS,  1'b0, '0},
			'{CMD_END,  8'hA5,    1'b0, '0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
		wait_drained();

		// Random expressions with occasional stray bytes and broken endings
		while (rand_items < 1600) begin
			if (rand_items >= 1350 || (rand_items >= 500 && rand_items < 750)) idle_on = 1'b0;
			else idle_on = 1'b1;
			if (!paused && rand_items >= 800) begin
				wait_drained();
				paused = 1'b1;
			end
			expr_buf.delete();
			if ($urandom_range(0, 9) == 0)
				put_byte($urandom_range(0, 1) ? CH_CLOSE : CH_OPEN);
			put_expr(0);
			foreach (expr_buf[i]) send_item(CMD_CHAR, expr_buf[i], 1'b0, '0);
			rand_items += expr_buf.size();
			// mostly close each expression; sometimes run on into the next one
			if ($urandom_range(0, 15) != 0) begin
				junk = CH_BITS'($urandom_range(0, 255));
				send_item(CMD_END, junk, 1'b0, '0);
				rand_items++;
			end
		end
		send_item(CMD_END, 8'h00, 1'b0, '0);

		// Let the pipeline empty
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_terms.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Hard stop if the pipeline hangs
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/etts_pkg.sv
rtl/core/etts_scan.sv
rtl/core/etts_out_reg.sv
rtl/core/expression_top_level_term_splitter.sv
test/testbench.sv
